@@ src/task_slot_table_scheduler_unit_macros.svh @@
// Assertion macros for the task slot table scheduler.
// Used by the top level only; depends on nothing else.
`ifndef TASK_SLOT_TABLE_SCHEDULER_UNIT_MACROS_SVH
`define TASK_SLOT_TABLE_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSTS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/tsts_pkg.sv @@
// Shared types and constants for the task slot table scheduler.
// Used by the controller, the datapath and the top level.
package tsts_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ACT_W = 2;
  localparam int ID_W = 16;
  localparam int TICK_W = 32;
  localparam int OUT_IDX_W = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef logic [OUT_IDX_W-1:0] out_idx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT        = 2'd0,
    ACT_DELETE        = 2'd1,
    ACT_DELETE_OTHERS = 2'd2,
    ACT_EXECUTE       = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             scan;
    logic             ins_wr;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    action_t op;
    logic    hit;
  } dp_stat_t;

endpackage

@@ src/tsts_ctrl.sv @@
// Controller state machine: accepts a command and steps the slot scan.
// Depends on tsts_pkg.
module tsts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tsts_pkg::dp_stat_t stat,
  output logic               busy,
  output tsts_pkg::dp_cmd_t  cmd
);

  tsts_pkg::state_t state, state_next;
  logic [tsts_pkg::IDX_W-1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsts_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    unique case (state)
      tsts_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          idx_next   = '0;
          state_next = tsts_pkg::ST_SCAN;
        end
      end
      tsts_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.op == tsts_pkg::ACT_DELETE && stat.hit) begin
          state_next = tsts_pkg::ST_IDLE;
        end else if (idx == tsts_pkg::LAST_IDX) begin
          state_next = (stat.op == tsts_pkg::ACT_INSERT) ? tsts_pkg::ST_INSERT
                                                         : tsts_pkg::ST_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      tsts_pkg::ST_INSERT: begin
        cmd.ins_wr = 1'b1;
        state_next = tsts_pkg::ST_IDLE;
      end
      default: begin
        state_next = tsts_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != tsts_pkg::ST_IDLE);

endmodule

@@ src/tsts_dp.sv @@
// Datapath: slot table, command registers and dispatch result registers.
// Depends on tsts_pkg; driven by tsts_ctrl.
module tsts_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tsts_pkg::dp_cmd_t             cmd,
  input  logic [tsts_pkg::ACT_W-1:0]    action,
  input  logic [tsts_pkg::ID_W-1:0]     task_id,
  input  logic [tsts_pkg::TICK_W-1:0]   now_tick,
  output tsts_pkg::dp_stat_t            stat,
  output logic                          strobe,
  output logic [tsts_pkg::OUT_IDX_W-1:0] slot_index,
  output logic [tsts_pkg::ID_W-1:0]     dispatched_id,
  output logic [tsts_pkg::TICK_W-1:0]   elapsed_ticks,
  output logic                          last
);

  tsts_pkg::action_t op_r;
  logic [tsts_pkg::ID_W-1:0]   id_r;
  logic [tsts_pkg::TICK_W-1:0] now_r;
  logic                        dup_found;
  logic                        free_found;
  logic [tsts_pkg::IDX_W-1:0]  free_idx;

  logic [tsts_pkg::ID_W-1:0]   slot_task [tsts_pkg::SLOT_COUNT];
  logic [tsts_pkg::TICK_W-1:0] slot_tick [tsts_pkg::SLOT_COUNT];

  logic [tsts_pkg::ID_W-1:0]       cur_task;
  logic [tsts_pkg::TICK_W-1:0]     cur_tick;
  logic                            cur_busy;
  logic                            hit;
  logic [tsts_pkg::SLOT_COUNT-1:0] occ;
  logic [tsts_pkg::SLOT_COUNT-1:0] later;

  always_comb begin
    for (int i = 0; i < tsts_pkg::SLOT_COUNT; i++) begin
      occ[i] = (slot_task[i] != '0);
    end
  end

  assign cur_task = slot_task[cmd.idx];
  assign cur_tick = slot_tick[cmd.idx];
  assign cur_busy = (cur_task != '0);
  assign hit      = (cur_task == id_r) && (id_r != '0);
  assign later    = (occ >> cmd.idx) >> 1;

  assign stat.op  = op_r;
  assign stat.hit = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tsts_pkg::SLOT_COUNT; i++) begin
        slot_task[i] <= '0;
      end
      strobe     <= 1'b0;
      dup_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.load) begin
        op_r       <= tsts_pkg::action_t'(action);
        id_r       <= task_id;
        now_r      <= now_tick;
        dup_found  <= 1'b0;
        free_found <= 1'b0;
      end
      if (cmd.scan) begin
        case (op_r)
          tsts_pkg::ACT_INSERT: begin
            if (hit) begin
              dup_found <= 1'b1;
            end
            if (!cur_busy && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmd.idx;
            end
          end
          tsts_pkg::ACT_DELETE: begin
            if (hit) begin
              slot_task[cmd.idx] <= '0;
              slot_tick[cmd.idx] <= '0;
            end
          end
          tsts_pkg::ACT_DELETE_OTHERS: begin
            if (cur_task != id_r || id_r == '0) begin
              slot_task[cmd.idx] <= '0;
              slot_tick[cmd.idx] <= '0;
            end
          end
          tsts_pkg::ACT_EXECUTE: begin
            if (cur_busy) begin
              strobe             <= 1'b1;
              slot_index         <= tsts_pkg::out_idx_t'(cmd.idx);
              dispatched_id      <= cur_task;
              elapsed_ticks      <= now_r - cur_tick;
              last               <= (later == '0);
              slot_tick[cmd.idx] <= now_r;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.ins_wr && !dup_found && free_found && id_r != '0) begin
        slot_task[free_idx] <= id_r;
        slot_tick[free_idx] <= '0;
      end
    end
  end

endmodule

@@ src/task_slot_table_scheduler_unit.sv @@
// Task slot table scheduler top level: controller plus datapath, one slot scanned per cycle.
// A command is loaded, then the scan steps through the slots; insert ends in a write state.
// Delete stops early at its first match. A new command is accepted only while busy is low.
// Execute gives a result for each occupied slot, registered in the cycle after its scan.
// Reset empties the table; results are never stalled by the receiver.
`include "task_slot_table_scheduler_unit_macros.svh"

module task_slot_table_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tsts_pkg::ACT_W-1:0]    action,
  input  logic [tsts_pkg::ID_W-1:0]     task_id,
  input  logic [tsts_pkg::TICK_W-1:0]   now_tick,
  output logic                          strobe,
  output logic [tsts_pkg::OUT_IDX_W-1:0] slot_index,
  output logic [tsts_pkg::ID_W-1:0]     dispatched_id,
  output logic [tsts_pkg::TICK_W-1:0]   elapsed_ticks,
  output logic                          last
);

  tsts_pkg::dp_cmd_t  cmd;
  tsts_pkg::dp_stat_t stat;

  tsts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  tsts_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .action        (action),
    .task_id       (task_id),
    .now_tick      (now_tick),
    .stat          (stat),
    .strobe        (strobe),
    .slot_index    (slot_index),
    .dispatched_id (dispatched_id),
    .elapsed_ticks (elapsed_ticks),
    .last          (last)
  );

  `TSTS_ASSERT_NOW(a_id_nonzero, clk, rst, strobe, dispatched_id != '0, "dispatched empty slot")
  `TSTS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted command not busy")
  `TSTS_ASSERT_NEXT(a_last_ends, clk, rst, strobe && last, !strobe, "result after last")
  `TSTS_ASSERT_NEXT(a_scan_cmd, clk, rst, cmd.load, cmd.scan, "scan did not follow load")

endmodule

@@ tb/task_slot_table_scheduler_unit_tb.sv @@
// Self-checking testbench for task_slot_table_scheduler_unit: a directed table, then random
// commands, each dispatch checked against a behavioral table or a directed row's result.
// Depends on tsts_pkg and the scheduler RTL only.
`timescale 1ns / 100ps

module task_slot_table_scheduler_unit_tb;

  typedef struct packed {
    tsts_pkg::out_idx_t          slot;
    logic [tsts_pkg::ID_W-1:0]   id;
    logic [tsts_pkg::TICK_W-1:0] elapsed;
    logic                        last;
  } dispatch_t;

  typedef struct {
    tsts_pkg::action_t           act;
    logic [tsts_pkg::ID_W-1:0]   id;
    logic [tsts_pkg::TICK_W-1:0] tick;
    bit                          typed;
    int                          n;
    dispatch_t                   res;
  } row_t;

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic [tsts_pkg::ACT_W-1:0]     action;
  logic [tsts_pkg::ID_W-1:0]      task_id;
  logic [tsts_pkg::TICK_W-1:0]    now_tick;
  logic                           strobe;
  logic [tsts_pkg::OUT_IDX_W-1:0] slot_index;
  logic [tsts_pkg::ID_W-1:0]      dispatched_id;
  logic [tsts_pkg::TICK_W-1:0]    elapsed_ticks;
  logic                           last;

  logic [tsts_pkg::ID_W-1:0]   table_ids [tsts_pkg::SLOT_COUNT];
  logic [tsts_pkg::TICK_W-1:0] table_ticks [tsts_pkg::SLOT_COUNT];
  dispatch_t                   dispatch_q [$];
  row_t                        rows [$];
  int                          errors;

  task_slot_table_scheduler_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .task_id      (task_id),
    .now_tick     (now_tick),
    .strobe       (strobe),
    .slot_index   (slot_index),
    .dispatched_id(dispatched_id),
    .elapsed_ticks(elapsed_ticks),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("task_slot_table_scheduler_unit_tb: FAIL");
    $finish;
  end

  // Applies a command to the behavioral table; if record is set, execute queues dispatches.
  task automatic update_table(input tsts_pkg::action_t act,
                              input logic [tsts_pkg::ID_W-1:0] id,
                              input logic [tsts_pkg::TICK_W-1:0] tick, input bit record);
    int        s;
    int        n;
    bit        done;
    dispatch_t d;
    dispatch_t pass_q [$];
    done = 1'b0;
    case (act)
      tsts_pkg::ACT_INSERT: begin
        if (id == 0) done = 1'b1;
        for (s = 0; s < tsts_pkg::SLOT_COUNT; s++)
          if (table_ids[s] == id) done = 1'b1;
        for (s = 0; s < tsts_pkg::SLOT_COUNT; s++) begin
          if (!done && table_ids[s] == 0) begin
            table_ids[s] = id;
            table_ticks[s] = '0;
            done = 1'b1;
          end
        end
      end
      tsts_pkg::ACT_DELETE: begin
        for (s = 0; s < tsts_pkg::SLOT_COUNT; s++) begin
          if (!done && id != 0 && table_ids[s] == id) begin
            table_ids[s] = '0;
            table_ticks[s] = '0;
            done = 1'b1;
          end
        end
      end
      tsts_pkg::ACT_DELETE_OTHERS: begin
        for (s = 0; s < tsts_pkg::SLOT_COUNT; s++) begin
          if (table_ids[s] != id || id == 0) begin
            table_ids[s] = '0;
            table_ticks[s] = '0;
          end
        end
      end
      default: begin
        for (s = 0; s < tsts_pkg::SLOT_COUNT; s++) begin
          if (table_ids[s] != 0) begin
            d.slot = tsts_pkg::out_idx_t'(s);
            d.id = table_ids[s];
            d.elapsed = tick - table_ticks[s];
            d.last = 1'b0;
            table_ticks[s] = tick;
            pass_q.push_back(d);
          end
        end
        n = pass_q.size();
        if (n > 0) pass_q[n-1].last = 1'b1;
        if (record)
          foreach (pass_q[i]) dispatch_q.push_back(pass_q[i]);
      end
    endcase
  endtask

  task issue(input tsts_pkg::action_t act, input logic [tsts_pkg::ID_W-1:0] id,
             input logic [tsts_pkg::TICK_W-1:0] tick, input int gap, input bit drain);
    if (gap > 0 || (drain && dispatch_q.size() != 0)) start <= 1'b0;
    repeat (gap) @(posedge clk);
    if (drain)
      while (dispatch_q.size() != 0) @(posedge clk);
    start <= 1'b1;
    action <= act;
    task_id <= id;
    now_tick <= tick;
    do @(posedge clk); while (busy);
  endtask

  task add_row(input tsts_pkg::action_t act, input logic [tsts_pkg::ID_W-1:0] id,
               input logic [tsts_pkg::TICK_W-1:0] tick, input int typed, input int n,
               input int slot, input int rid, input logic [tsts_pkg::TICK_W-1:0] el);
    row_t r;
    r.act = act;
    r.id = id;
    r.tick = tick;
    r.typed = (typed != 0);
    r.n = n;
    r.res = '{slot: slot[tsts_pkg::OUT_IDX_W-1:0], id: rid[tsts_pkg::ID_W-1:0],
              elapsed: el, last: 1'b1};
    rows.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (dispatch_q.size() == 0) begin
        $display("%0t: unexpected dispatch, actual slot %0d id %h elapsed %h last %b",
                 $time, slot_index, dispatched_id, elapsed_ticks, last);
        errors++;
      end else begin
        if (dispatch_q[0] != {slot_index, dispatched_id, elapsed_ticks, last}) begin
          $display("%0t: dispatch mismatch, expected slot %0d id %h elapsed %h last %b,",
                   $time, dispatch_q[0].slot, dispatch_q[0].id, dispatch_q[0].elapsed,
                   dispatch_q[0].last);
          $display("    actual slot %0d id %h elapsed %h last %b",
                   slot_index, dispatched_id, elapsed_ticks, last);
          errors++;
        end
        void'(dispatch_q.pop_front());
      end
    end
  end

  initial begin
    logic [tsts_pkg::ID_W-1:0]   pool [12];
    logic [tsts_pkg::TICK_W-1:0] clock_now;
    logic [tsts_pkg::ID_W-1:0]   id;
    logic [tsts_pkg::TICK_W-1:0] tick;
    tsts_pkg::action_t           act;
    int                          pick;
    int                          gap;
    int                          wait_cycles;

    errors = 0;
    rst <= 1'b1;
    start <= 1'b0;
    action <= tsts_pkg::ACT_INSERT;
    task_id <= '0;
    now_tick <= '0;
    foreach (table_ids[s]) begin
      table_ids[s] = '0;
      table_ticks[s] = '0;
    end

    add_row(tsts_pkg::ACT_EXECUTE, 16'h0000, 32'h0000_0005, 1, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_INSERT, 16'h0000, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_DELETE, 16'h0000, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_INSERT, 16'hFFFF, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_EXECUTE, 16'h0000, 32'hFFFF_FFFF, 1, 1, 0, 16'hFFFF, 32'hFFFF_FFFF);
    add_row(tsts_pkg::ACT_EXECUTE, 16'hFFFF, 32'h0000_0000, 1, 1, 0, 16'hFFFF, 32'h0000_0001);
    add_row(tsts_pkg::ACT_INSERT, 16'hFFFF, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_INSERT, 16'h0001, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_INSERT, 16'h8000, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_INSERT, 16'h5555, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_INSERT, 16'hAAAA, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_INSERT, 16'h00FF, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_INSERT, 16'hFF00, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_INSERT, 16'h1234, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_INSERT, 16'h4321, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_EXECUTE, 16'h0000, 32'h8000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_DELETE, 16'h4321, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_DELETE, 16'h5555, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_INSERT, 16'h4321, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_EXECUTE, 16'h0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_DELETE_OTHERS, 16'h8000, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_EXECUTE, 16'h0000, 32'h0000_0064, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_DELETE_OTHERS, 16'h0000, 32'h0000_0000, 0, 0, 0, 0, 0);
    add_row(tsts_pkg::ACT_EXECUTE, 16'h0000, 32'h0000_0003, 1, 0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      issue(rows[i].act, rows[i].id, rows[i].tick, 0, 1'b0);
      update_table(rows[i].act, rows[i].id, rows[i].tick, !rows[i].typed);
      if (rows[i].typed && rows[i].n > 0) dispatch_q.push_back(rows[i].res);
    end

    // Most ids come from a small pool so that duplicates, hits and a full table are common.
    foreach (pool[i]) begin
      pick = $urandom_range(1, 65535);
      pool[i] = pick[tsts_pkg::ID_W-1:0];
    end
    clock_now = $urandom();
    for (int i = 0; i < 250; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) act = tsts_pkg::ACT_INSERT;
      else if (pick < 55) act = tsts_pkg::ACT_DELETE;
      else if (pick < 60) act = tsts_pkg::ACT_DELETE_OTHERS;
      else act = tsts_pkg::ACT_EXECUTE;
      pick = $urandom_range(0, 99);
      if (pick < 80) id = pool[$urandom_range(0, 11)];
      else if (pick < 85) id = '0;
      else begin
        pick = $urandom_range(0, 65535);
        id = pick[tsts_pkg::ID_W-1:0];
      end
      if (act == tsts_pkg::ACT_EXECUTE) begin
        if ($urandom_range(0, 19) == 0) clock_now = $urandom();
        else clock_now = clock_now + $urandom_range(0, 5000);
        tick = clock_now;
      end else begin
        tick = $urandom();
      end
      if (i >= 100 && i < 180) gap = 0;
      else gap = ($urandom_range(0, 99) < 7) ? $urandom_range(1, 6) : 0;
      issue(act, id, tick, gap, i == 50 || i == 200);
      update_table(act, id, tick, 1'b1);
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (dispatch_q.size() != 0 && wait_cycles < 200) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2 * tsts_pkg::SLOT_COUNT + 4) @(posedge clk);
    if (dispatch_q.size() != 0) begin
      $display("%0t: %0d expected dispatch transactions never arrived",
               $time, dispatch_q.size());
      errors++;
    end
    if (errors == 0)
      $display("task_slot_table_scheduler_unit_tb: PASS");
    else
      $display("task_slot_table_scheduler_unit_tb: FAIL");
    $finish;
  end

endmodule
